>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Default form on clk_i / rst_ni.
`define ASSERT_CLK(name, prop, msg) `ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/lste_pkg.sv
// ----------------------------------------------------------------------------
// lste_pkg
// Types, constants and helpers for the LED strip tracer effect.
// ----------------------------------------------------------------------------
`default_nettype none

package lste_pkg;

  localparam int NUM_LEDS_DEF = 32;
  localparam int LED_IDX_W    = 6;
  localparam int CH_W         = 8;
  localparam int CFG_IDX_W    = 3;

  typedef logic [CH_W-1:0] chan_t;

  localparam chan_t CHAN_ON         = 8'd255;
  localparam chan_t RST_STEP_PERIOD = 8'd5;
  localparam chan_t RST_DECAY_STEP  = 8'd3;
  localparam chan_t RST_BACKGROUND  = 8'd2;
  localparam chan_t RST_LED0_DWELL  = 8'd5;
  localparam chan_t RST_LED0_RED    = 8'd200;
  localparam chan_t DWELL_LAST      = 8'd1;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    chan_t step_period;
    chan_t decay_step;
    rgb_t  background;
  } cfg_t;

  // Tracer hand-off from one LED to the next
  typedef struct packed {
    logic valid;
    rgb_t color;
  } hand_t;

  // Sequencer strobes to every cell
  typedef struct packed {
    logic upd;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic start_trace;
    logic start_red_on;
    logic start_green_on;
    logic start_blue_on;
  } in_item_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    chan_t                red;
    chan_t                green;
    chan_t                blue;
    logic                 last_led;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD = 3'd0,
    CFG_DECAY_STEP  = 3'd1,
    CFG_BG_RED      = 3'd2,
    CFG_BG_GREEN    = 3'd3,
    CFG_BG_BLUE     = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // Move cur toward target by at most lim, never past target.
  function automatic chan_t fade_toward(chan_t cur, chan_t target, chan_t lim);
    chan_t diff;
    chan_t res;
    if (cur < target) begin
      diff = target - cur;
      res  = (diff > lim) ? chan_t'(cur + lim) : target;
    end else begin
      diff = cur - target;
      res  = (diff > lim) ? chan_t'(cur - lim) : target;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lste_cell.sv
// ----------------------------------------------------------------------------
// lste_cell
// One LED: countdown, trace color and shown color, with tick update and
// shown-color ring shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lste_cell #(
  parameter lste_pkg::chan_t RST_DWELL = '0,
  parameter lste_pkg::rgb_t  RST_TRACE = '0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lste_pkg::cell_ctrl_t ctrl_i,
  input  lste_pkg::cfg_t       cfg_i,
  input  wire                  load_i,        // new tracer replaces this LED's
  input  lste_pkg::rgb_t       load_color_i,
  input  lste_pkg::hand_t      hand_i,        // from previous LED
  output lste_pkg::hand_t      hand_o,        // to next LED
  input  lste_pkg::rgb_t       shown_i,       // ring input from next LED
  output lste_pkg::rgb_t       shown_o
);
  import lste_pkg::*;

  chan_t dwell_q, dwell_d;
  rgb_t  trace_q, trace_d;
  rgb_t  shown_q, shown_d;
  chan_t eff_dwell;
  rgb_t  eff_trace;

  // State as seen after a possible tracer start
  assign eff_dwell = load_i ? cfg_i.step_period : dwell_q;
  assign eff_trace = load_i ? load_color_i : trace_q;

  assign hand_o.valid = (eff_dwell == DWELL_LAST);
  assign hand_o.color = eff_trace;
  assign shown_o      = shown_q;

  always_comb begin
    dwell_d = dwell_q;
    trace_d = trace_q;
    shown_d = shown_q;
    if (ctrl_i.shift) begin
      shown_d = shown_i;
    end
    if (ctrl_i.upd) begin
      trace_d = eff_trace;
      if (eff_dwell > DWELL_LAST) begin
        dwell_d = eff_dwell - DWELL_LAST;
      end else if (eff_dwell == DWELL_LAST) begin
        shown_d = eff_trace;
        dwell_d = '0;
      end else begin
        shown_d.red   = fade_toward(shown_q.red,   cfg_i.background.red,   cfg_i.decay_step);
        shown_d.green = fade_toward(shown_q.green, cfg_i.background.green, cfg_i.decay_step);
        shown_d.blue  = fade_toward(shown_q.blue,  cfg_i.background.blue,  cfg_i.decay_step);
        dwell_d       = '0;
      end
      // incoming tracer wins over this LED's own outcome
      if (hand_i.valid) begin
        dwell_d = cfg_i.step_period;
        trace_d = hand_i.color;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= RST_DWELL;
      trace_q <= RST_TRACE;
      shown_q <= '0;
    end else begin
      dwell_q <= dwell_d;
      trace_q <= trace_d;
      shown_q <= shown_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lste_ctrl.sv
// ----------------------------------------------------------------------------
// lste_ctrl
// Tick sequencer: an update strobe to every cell, then one result per LED.
// ----------------------------------------------------------------------------
`default_nettype none

module lste_ctrl #(
  parameter int NUM_LEDS = lste_pkg::NUM_LEDS_DEF,
  localparam int IdxW    = $clog2(NUM_LEDS)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output lste_pkg::cell_ctrl_t  ctrl_o,
  output logic [IdxW-1:0]       idx_o,
  output logic                  last_o
);
  import lste_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_LEDS - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o  = idx_q;
  assign last_o = (idx_q == LastIdx);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    ctrl_o.upd   = 1'b0;
    ctrl_o.shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.upd = 1'b1;
          idx_d      = '0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctrl_o.shift = 1'b1;
          idx_d        = idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/led_strip_tracer_effect.sv
// ----------------------------------------------------------------------------
// led_strip_tracer_effect
// Tracer animation over a strip of NUM_LEDS LEDs, one request per tick.
// ----------------------------------------------------------------------------
// Each accepted request is one animation tick. The strip is a ring of
// NUM_LEDS identical cells, one per LED, each holding that LED's countdown,
// trace color and shown color. In the cycle the request is accepted every
// cell updates at once, taking a tracer hand-off from its left neighbor
// (LED 0 takes the optional new tracer instead). Then the shown colors
// rotate through the ring toward cell 0, which drives the result port:
// one result per cycle while out_ready_i is high, LED 0 first, last_led on
// LED NUM_LEDS-1. After NUM_LEDS rotations every color is back in its own
// cell. A tick is the update followed by one LED result at a time, set by
// the single result port at the head of the ring. A new request is taken
// once the last result of a tick is taken. Configuration writes are always
// accepted (cfg_ready_o is tied high) and must only be issued while no tick
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module led_strip_tracer_effect #(
  parameter int NUM_LEDS = lste_pkg::NUM_LEDS_DEF   // 2 .. 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // tick requests
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  lste_pkg::in_item_t                 in_item_i,
  // per-LED results
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output lste_pkg::out_item_t                out_item_o,
  // register writes
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [lste_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [lste_pkg::CH_W-1:0]           cfg_data_i
);
  import lste_pkg::*;

  localparam int IdxW = $clog2(NUM_LEDS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_period      <= RST_STEP_PERIOD;
      cfg_q.decay_step       <= RST_DECAY_STEP;
      cfg_q.background.red   <= RST_BACKGROUND;
      cfg_q.background.green <= RST_BACKGROUND;
      cfg_q.background.blue  <= RST_BACKGROUND;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_PERIOD: cfg_q.step_period      <= cfg_data_i;
        CFG_DECAY_STEP:  cfg_q.decay_step       <= cfg_data_i;
        CFG_BG_RED:      cfg_q.background.red   <= cfg_data_i;
        CFG_BG_GREEN:    cfg_q.background.green <= cfg_data_i;
        CFG_BG_BLUE:     cfg_q.background.blue  <= cfg_data_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  cell_ctrl_t      ctrl;
  logic [IdxW-1:0] idx;
  logic            last;

  lste_ctrl #(
    .NUM_LEDS (NUM_LEDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .idx_o       (idx),
    .last_o      (last)
  );

  // --------------------------------------------------------------------------
  // New tracer color for LED 0; only applied in the update cycle
  // --------------------------------------------------------------------------
  rgb_t start_color;
  logic start_load;

  assign start_color.red   = in_item_i.start_red_on   ? CHAN_ON : '0;
  assign start_color.green = in_item_i.start_green_on ? CHAN_ON : '0;
  assign start_color.blue  = in_item_i.start_blue_on  ? CHAN_ON : '0;
  assign start_load        = ctrl.upd & in_item_i.start_trace;

  // --------------------------------------------------------------------------
  // Cell ring. hand[i] enters cell i; the hand-off out of the last cell
  // falls off the end of the strip. shown[i] is cell i's shown color, and
  // each cell loads its right neighbor's on a shift (the last cell wraps to cell 0).
  // --------------------------------------------------------------------------
  hand_t hand  [NUM_LEDS+1];
  rgb_t  shown [NUM_LEDS];

  assign hand[0] = '0;

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_cell
    if (i == 0) begin : g_head
      lste_cell #(
        .RST_DWELL (RST_LED0_DWELL),
        .RST_TRACE ({RST_LED0_RED, CH_W'(0), CH_W'(0)})
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .cfg_i        (cfg_q),
        .load_i       (start_load),
        .load_color_i (start_color),
        .hand_i       (hand[i]),
        .hand_o       (hand[i+1]),
        .shown_i      (shown[(i+1) % NUM_LEDS]),
        .shown_o      (shown[i])
      );
    end else begin : g_body
      lste_cell #(
        .RST_DWELL ('0),
        .RST_TRACE ('0)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .cfg_i        (cfg_q),
        .load_i       (1'b0),
        .load_color_i ('0),
        .hand_i       (hand[i]),
        .hand_o       (hand[i+1]),
        .shown_i      (shown[(i+1) % NUM_LEDS]),
        .shown_o      (shown[i])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Result port: head of the ring plus the LED counter
  // --------------------------------------------------------------------------
  assign out_item_o.led_index = LED_IDX_W'(idx);
  assign out_item_o.red       = shown[0].red;
  assign out_item_o.green     = shown[0].green;
  assign out_item_o.blue      = shown[0].blue;
  assign out_item_o.last_led  = last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_CLK(a_req_res_excl, !(in_ready_o && out_valid_o), "request taken during results")
  `ASSERT_CLK(a_first_led, (in_valid_i && in_ready_o) |=> (out_valid_o && out_item_o.led_index == '0), "tick does not start at LED 0")
  `ASSERT_CLK(a_last_idx, (out_valid_o && out_item_o.last_led) |-> (out_item_o.led_index == LED_IDX_W'(NUM_LEDS - 1)), "last_led on wrong LED")
  `ASSERT_CLK(a_tick_done, (out_valid_o && out_ready_i && out_item_o.last_led) |=> in_ready_o, "no return to idle after last LED")

endmodule

`default_nettype wire

>>> dv/led_strip_color_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_strip_color_checker
// Predicts the LED colors of every tick and compares the result stream.
// ----------------------------------------------------------------------------
module led_strip_color_checker #(
  parameter int LEDS = lste_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  lste_pkg::in_item_t            in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  lste_pkg::out_item_t           out_item_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lste_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lste_pkg::CH_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import lste_pkg::*;

  // Strip state as the block should hold it
  chan_t dwell_q [LEDS];
  rgb_t  trail_q [LEDS];
  rgb_t  lit_q   [LEDS];
  chan_t period_r;
  chan_t decay_r;
  rgb_t  bg_r;

  out_item_t colors_due [$];

  function automatic chan_t ease_toward(chan_t level, chan_t goal, chan_t limit);
    int gap;
    gap = int'(goal) - int'(level);
    if (gap > int'(limit)) gap = int'(limit);
    else if (gap < -int'(limit)) gap = -int'(limit);
    return chan_t'(int'(level) + gap);
  endfunction

  task automatic restore_defaults();
    period_r = 8'd5;
    decay_r  = 8'd3;
    bg_r     = '{red: 8'd2, green: 8'd2, blue: 8'd2};
    for (int i = 0; i < LEDS; i++) begin
      dwell_q[i] = '0;
      trail_q[i] = '0;
      lit_q[i]   = '0;
    end
    dwell_q[0]       = 8'd5;
    trail_q[0].red   = 8'd200;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, chan_t val);
    case (idx)
      CFG_STEP_PERIOD: period_r = val;
      CFG_DECAY_STEP:  decay_r = val;
      CFG_BG_RED:      bg_r.red = val;
      CFG_BG_GREEN:    bg_r.green = val;
      CFG_BG_BLUE:     bg_r.blue = val;
      default: ;
    endcase
  endtask

  // One animation tick, then queue every LED's color
  task automatic advance_strip(in_item_t req);
    out_item_t rsp;
    if (req.start_trace) begin
      dwell_q[0]       = period_r;
      trail_q[0].red   = req.start_red_on   ? 8'd255 : 8'd0;
      trail_q[0].green = req.start_green_on ? 8'd255 : 8'd0;
      trail_q[0].blue  = req.start_blue_on  ? 8'd255 : 8'd0;
    end
    for (int i = LEDS - 1; i >= 0; i--) begin
      if (dwell_q[i] > 8'd1) begin
        dwell_q[i] = dwell_q[i] - 8'd1;
      end else begin
        if (dwell_q[i] == 8'd1) begin
          lit_q[i] = trail_q[i];
          if (i + 1 < LEDS) begin
            dwell_q[i+1] = period_r;
            trail_q[i+1] = trail_q[i];
          end
        end else begin
          lit_q[i].red   = ease_toward(lit_q[i].red,   bg_r.red,   decay_r);
          lit_q[i].green = ease_toward(lit_q[i].green, bg_r.green, decay_r);
          lit_q[i].blue  = ease_toward(lit_q[i].blue,  bg_r.blue,  decay_r);
        end
        dwell_q[i] = '0;
      end
    end
    for (int i = 0; i < LEDS; i++) begin
      rsp.led_index = LED_IDX_W'(i);
      rsp.red       = lit_q[i].red;
      rsp.green     = lit_q[i].green;
      rsp.blue      = lit_q[i].blue;
      rsp.last_led  = (i == LEDS - 1);
      colors_due.push_back(rsp);
    end
  endtask

  task automatic compare_color(out_item_t got);
    out_item_t want;
    if (colors_due.size() == 0) begin
      $error("unexpected LED color, led_index %0d", got.led_index);
      fail_count_o++;
    end else begin
      want = colors_due.pop_front();
      if (got.led_index !== want.led_index) begin
        $error("led_index: expected %0d, got %0d", want.led_index, got.led_index);
        fail_count_o++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        fail_count_o++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        fail_count_o++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        fail_count_o++;
      end
      if (got.last_led !== want.last_led) begin
        $error("last_led: expected %0d, got %0d", want.last_led, got.last_led);
        fail_count_o++;
      end
    end
    checked_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // pending_o moves with a nonblocking update so readers at the edge see
  // the count as of the previous edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_defaults();
      colors_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_index_i, cfg_data_i);
      if (out_valid_i && out_ready_i) compare_color(out_item_i);
      if (in_valid_i && in_ready_i) advance_strip(in_item_i);
      pending_o <= colors_due.size();
    end
  end

endmodule

>>> dv/tb_led_strip_tracer_effect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_strip_tracer_effect
// Tick stimulus, register phases and verdict for the tracer effect.
// ----------------------------------------------------------------------------
// A directed burst under reset settings walks the power-up tracer and every
// start color, then randomized phases run under different register settings
// (step period 0, 1 and 255, decay 0 and 255, background extremes). The
// checker beside the block predicts each LED color and counts mismatches.
// ----------------------------------------------------------------------------
module tb_led_strip_tracer_effect;
  import lste_pkg::*;

  localparam int LEDS = NUM_LEDS_DEF;
  // index with no register behind it; the write must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             tick_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_item_t            led_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int ticks_sent = 0;
  int settings_used = 0;
  // set for the final phase: no gaps and no stalls
  bit calm = 1'b0;

  led_strip_tracer_effect #(.NUM_LEDS(LEDS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (tick_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (led_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  led_strip_color_checker #(.LEDS(LEDS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (tick_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (led_rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Result side: ready bursts of varying length broken by stalls until calm is set
  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  function automatic in_item_t make_tick(bit go, bit r_on, bit g_on, bit b_on);
    in_item_t req;
    req.start_trace    = go;
    req.start_red_on   = r_on;
    req.start_green_on = g_on;
    req.start_blue_on  = b_on;
    return req;
  endfunction

  function automatic cfg_t make_cfg(int period, int decay, int r, int g, int b);
    cfg_t c;
    c.step_period      = chan_t'(period);
    c.decay_step       = chan_t'(decay);
    c.background.red   = chan_t'(r);
    c.background.green = chan_t'(g);
    c.background.blue  = chan_t'(b);
    return c;
  endfunction

  // Valid stays high on return; the caller lowers it only when it idles
  task automatic send_tick(in_item_t req);
    in_valid <= 1'b1;
    tick_req <= req;
    do @(posedge clk_i); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic hold_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait until every LED color of the last tick is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LEDS + 4) @(posedge clk_i);
  endtask

  task automatic wait_cfg();
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // All five registers back to back, sometimes a stray index at the end
  task automatic write_regs(cfg_t c);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STEP_PERIOD;
    cfg_data  <= c.step_period;
    wait_cfg();
    cfg_index <= CFG_DECAY_STEP;
    cfg_data  <= c.decay_step;
    wait_cfg();
    cfg_index <= CFG_BG_RED;
    cfg_data  <= c.background.red;
    wait_cfg();
    cfg_index <= CFG_BG_GREEN;
    cfg_data  <= c.background.green;
    wait_cfg();
    cfg_index <= CFG_BG_BLUE;
    cfg_data  <= c.background.blue;
    wait_cfg();
    if ($urandom_range(0, 1)) begin
      cfg_index <= CFG_SPARE_IDX;
      cfg_data  <= chan_t'($urandom);
      wait_cfg();
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random ticks under one register setting; start_pct sets tracer density
  task automatic run_phase(cfg_t c, int count, int start_pct);
    in_item_t req;
    settle();
    write_regs(c);
    for (int k = 0; k < count; k++) begin
      req = make_tick($urandom_range(0, 99) < start_pct, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_tick(req);
      if (!calm && $urandom_range(0, 9) < 2) hold_input($urandom_range(1, 11));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-up tracer: rests five ticks on LED 0, then moves on
    repeat (6) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    // every start color; back-to-back starts replace the tracer on LED 0
    for (int c = 0; c < 8; c++) send_tick(make_tick(1'b1, c[2], c[1], c[0]));
    // color bits without a start change nothing
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1));
    hold_input(3);
    repeat (6) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));

    // no fade at all, tracer moves every tick and runs off the far end
    run_phase(make_cfg(1, 0, 0, 0, 0), 60, 30);
    // zero period: a new tracer never shows; full-range fade
    run_phase(make_cfg(0, 255, 255, 0, 255), 40, 50);
    // longest dwell, slowest nonzero fade
    run_phase(make_cfg(255, 1, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255)), 30, 40);
    run_phase(make_cfg(2, $urandom_range(2, 20), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255)), 80, 35);
    run_phase(make_cfg(1, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255)), 90, 15);
    run_phase(make_cfg($urandom_range(1, 4), $urandom_range(0, 40),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255)), 80, 25);

    // last stretch runs at full rate on both sides
    calm = 1'b1;
    run_phase(make_cfg(3, 3, 2, 2, 2), 70, 20);
    settle();

    $display("Covered %0d ticks under %0d register settings plus reset values",
             ticks_sent, settings_used);
    $display("%0d LED colors compared against the prediction", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d LED colors still due", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lste_pkg.sv
rtl/core/lste_cell.sv
rtl/core/lste_ctrl.sv
rtl/core/led_strip_tracer_effect.sv
dv/led_strip_color_checker.sv
dv/tb_led_strip_tracer_effect.sv
